@@ src/irpw_pkg.sv @@
// Package for the IR pulse-width frame decoder.
// Holds the register map, the configuration and result types and the frame layout.
// No dependencies.
`default_nettype none

package irpw_pkg;

  localparam int CFG_W      = 13;  // width of every configuration register
  localparam int CFG_IDX_W  = 3;
  localparam int FRAME_BITS = 16;
  localparam int POS_W      = 5;   // holds a bit position up to FRAME_BITS
  localparam int FIELD_W    = 5;
  localparam int COUNT_W    = 2;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW_MIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW_MAX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW_MAX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_TIMEOUT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_WINDOW = 3'd5;

  // Reset values
  localparam logic [CFG_W-1:0] RST_ZERO_LOW_MIN  = 13'd700;
  localparam logic [CFG_W-1:0] RST_ZERO_LOW_MAX  = 13'd900;
  localparam logic [CFG_W-1:0] RST_ONE_LOW_MIN   = 13'd1500;
  localparam logic [CFG_W-1:0] RST_ONE_LOW_MAX   = 13'd1700;
  localparam logic [CFG_W-1:0] RST_HIGH_TIMEOUT  = 13'd4000;
  localparam logic [CFG_W-1:0] RST_REPEAT_WINDOW = 13'd4000;

  typedef struct packed {
    logic [CFG_W-1:0] zero_low_min;
    logic [CFG_W-1:0] zero_low_max;
    logic [CFG_W-1:0] one_low_min;
    logic [CFG_W-1:0] one_low_max;
    logic [CFG_W-1:0] high_timeout;
    logic [CFG_W-1:0] repeat_window;
  } cfg_t;

  typedef struct packed {
    logic [FRAME_BITS-1:0] frame_word;
    logic [FIELD_W-1:0]    player_field;
    logic [FIELD_W-1:0]    data_field;
    logic [FIELD_W-1:0]    check_field;
    logic                  check_ok;
    logic                  frame_corrupt;
    logic [COUNT_W-1:0]    repeat_count;
  } result_t;

endpackage

`default_nettype wire

@@ src/irpw_in_if.sv @@
// Input channel: one receiver pin sample per transaction.
// Depends on nothing.
`default_nettype none

interface irpw_in_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink   (input valid, input pin_level, output ready);
endinterface

`default_nettype wire

@@ src/irpw_out_if.sv @@
// Result channel: one decoded or aborted frame per transaction.
// Uses irpw_pkg for field widths.
`default_nettype none

interface irpw_out_if;
  logic                                             valid;
  logic                                             ready;
  logic [irpw_pkg::FRAME_BITS-1:0]                  frame_word;
  logic [irpw_pkg::FIELD_W-1:0]                     player_field;
  logic [irpw_pkg::FIELD_W-1:0]                     data_field;
  logic [irpw_pkg::FIELD_W-1:0]                     check_field;
  logic                                             check_ok;
  logic                                             frame_corrupt;
  logic [irpw_pkg::COUNT_W-1:0]                     repeat_count;

  modport source (output valid, output frame_word, output player_field, output data_field,
                  output check_field, output check_ok, output frame_corrupt,
                  output repeat_count, input ready);
  modport sink   (input valid, input frame_word, input player_field, input data_field,
                  input check_field, input check_ok, input frame_corrupt,
                  input repeat_count, output ready);
endinterface

`default_nettype wire

@@ src/irpw_cfg_if.sv @@
// Configuration write channel: register index and write data.
// Uses irpw_pkg for widths.
`default_nettype none

interface irpw_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [irpw_pkg::CFG_IDX_W-1:0]  index;
  logic [irpw_pkg::CFG_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ src/irpw_cfg_regs.sv @@
// Configuration register file for the IR frame decoder.
// Uses irpw_pkg (register map, cfg_t) and irpw_cfg_if.
`default_nettype none

module irpw_cfg_regs (
  input  wire logic      clk,
  input  wire logic      rst_n,
  irpw_cfg_if.sink       cfg_ch,
  output irpw_pkg::cfg_t cfg
);

  irpw_pkg::cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zero_low_min  <= irpw_pkg::RST_ZERO_LOW_MIN;
      cfg_r.zero_low_max  <= irpw_pkg::RST_ZERO_LOW_MAX;
      cfg_r.one_low_min   <= irpw_pkg::RST_ONE_LOW_MIN;
      cfg_r.one_low_max   <= irpw_pkg::RST_ONE_LOW_MAX;
      cfg_r.high_timeout  <= irpw_pkg::RST_HIGH_TIMEOUT;
      cfg_r.repeat_window <= irpw_pkg::RST_REPEAT_WINDOW;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        irpw_pkg::REG_ZERO_LOW_MIN:  cfg_r.zero_low_min  <= cfg_ch.data;
        irpw_pkg::REG_ZERO_LOW_MAX:  cfg_r.zero_low_max  <= cfg_ch.data;
        irpw_pkg::REG_ONE_LOW_MIN:   cfg_r.one_low_min   <= cfg_ch.data;
        irpw_pkg::REG_ONE_LOW_MAX:   cfg_r.one_low_max   <= cfg_ch.data;
        irpw_pkg::REG_HIGH_TIMEOUT:  cfg_r.high_timeout  <= cfg_ch.data;
        irpw_pkg::REG_REPEAT_WINDOW: cfg_r.repeat_window <= cfg_ch.data;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/irpw_core.sv @@
// Decoder state and per-tick step logic: pulse timing, bit classification,
// frame assembly and repeat tracking. Uses irpw_pkg (cfg_t, result_t).
`default_nettype none

module irpw_core #(
  parameter int TIMER_BITS = 13
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step,
  input  wire logic           pin,
  input  wire irpw_pkg::cfg_t cfg,
  output logic                emit,
  output irpw_pkg::result_t   result
);

  localparam int CMP_W = (TIMER_BITS > irpw_pkg::CFG_W) ? TIMER_BITS : irpw_pkg::CFG_W;
  localparam logic [TIMER_BITS-1:0] TMAX = '1;
  localparam logic [TIMER_BITS-1:0] TONE = TIMER_BITS'(1);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;

  localparam logic [irpw_pkg::POS_W-1:0] POS_LAST = irpw_pkg::POS_W'(irpw_pkg::FRAME_BITS);
  localparam logic [irpw_pkg::COUNT_W-1:0] CNT_ONE = irpw_pkg::COUNT_W'(1);

  logic [1:0]                          phase_r, phase_nxt;
  logic [irpw_pkg::POS_W-1:0]          pos_r, pos_nxt, pos_inc;
  logic [irpw_pkg::FRAME_BITS-1:0]     shift_r, shift_nxt, shift_new;
  logic [TIMER_BITS-1:0]               dur_r, dur_nxt, dur_inc;
  logic                                rep_r, rep_nxt, rep_new;
  logic [irpw_pkg::COUNT_W-1:0]        frames_r, frames_nxt;
  logic [TIMER_BITS-1:0]               since_r, since_nxt, since_inc;

  logic [CMP_W-1:0] dur_x, since_x;
  logic             is_zero, is_one;
  logic [irpw_pkg::FIELD_W-1:0] pl, da, ck;

  assign dur_inc   = (dur_r == TMAX) ? TMAX : dur_r + TONE;
  assign since_inc = (since_r == TMAX) ? TMAX : since_r + TONE;
  assign dur_x     = CMP_W'(dur_r);
  assign since_x   = CMP_W'(since_r);

  // exclusive bounds, zero test wins
  assign is_zero = (dur_x > CMP_W'(cfg.zero_low_min)) && (dur_x < CMP_W'(cfg.zero_low_max));
  assign is_one  = (dur_x > CMP_W'(cfg.one_low_min))  && (dur_x < CMP_W'(cfg.one_low_max));

  assign shift_new = {shift_r[irpw_pkg::FRAME_BITS-2:0], ~is_zero};
  assign pos_inc   = pos_r + irpw_pkg::POS_W'(1);
  assign rep_new   = rep_r || ((frames_r == CNT_ONE) &&
                               (since_x <= CMP_W'(cfg.repeat_window)));

  assign pl = shift_new[14:10];
  assign da = shift_new[9:5];
  assign ck = shift_new[4:0];

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    shift_nxt  = shift_r;
    dur_nxt    = dur_r;
    rep_nxt    = rep_r;
    frames_nxt = frames_r;
    since_nxt  = since_inc;
    emit       = 1'b0;
    // default is the abort report: bits so far, everything else zero
    result               = '0;
    result.frame_word    = shift_r;
    result.frame_corrupt = 1'b1;

    case (phase_r)
      PH_HIGH: begin
        if (pin) begin
          dur_nxt = dur_inc;
          if (CMP_W'(dur_inc) >= CMP_W'(cfg.high_timeout)) begin
            emit = 1'b1;
          end
        end else begin
          phase_nxt = PH_LOW;
          dur_nxt   = TONE;
        end
      end
      PH_LOW: begin
        if (!pin) begin
          dur_nxt = dur_inc;
        end else if (!is_zero && !is_one) begin
          emit = 1'b1;
        end else if (pos_inc == POS_LAST) begin
          // last bit: report the frame
          emit                 = 1'b1;
          frames_nxt           = rep_new ? frames_r + CNT_ONE : CNT_ONE;
          since_nxt            = '0;
          result.frame_word    = shift_new;
          result.player_field  = pl;
          result.data_field    = da;
          result.check_field   = ck;
          result.check_ok      = (ck == (pl ^ da));
          result.frame_corrupt = 1'b0;
          result.repeat_count  = frames_nxt;
        end else begin
          phase_nxt = PH_HIGH;
          dur_nxt   = '0;
          shift_nxt = shift_new;
          pos_nxt   = pos_inc;
          rep_nxt   = rep_new;
        end
      end
      default: begin
        phase_nxt = pin ? PH_IDLE : PH_LOW;
        if (!pin) begin
          dur_nxt = TONE;
        end
      end
    endcase

    // any report ends the frame
    if (emit) begin
      phase_nxt = PH_IDLE;
      pos_nxt   = '0;
      shift_nxt = '0;
      dur_nxt   = '0;
      rep_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      pos_r    <= '0;
      shift_r  <= '0;
      dur_r    <= '0;
      rep_r    <= 1'b0;
      frames_r <= '0;
      since_r  <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      shift_r  <= shift_nxt;
      dur_r    <= dur_nxt;
      rep_r    <= rep_nxt;
      frames_r <= frames_nxt;
      since_r  <= since_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/ir_pulse_width_frame_decoder.sv @@
// Top level of the IR pulse-width frame decoder: input register, decoder core,
// result register and configuration registers. Uses irpw_pkg, the three channel
// interfaces, irpw_cfg_regs and irpw_core.
//
//   channel  direction  transaction carries
//   -------  ---------  ---------------------------------------------------------
//   in_ch    sink       pin_level, one sample per microsecond tick
//   out_ch   source     frame_word, player/data/check fields, check_ok,
//                       frame_corrupt, repeat_count
//   cfg_ch   sink       index (0..5) and 13-bit data, always ready
//
// One sample per cycle is accepted unless the result register stalls; each sample
// goes input register -> step logic -> result register, which offers the result
// of the sample that ends the frame. Most samples give no result and only update
// state. A stalled result register holds the step stage; the input register still
// takes one more sample. Synchronous active-low reset restores the register
// defaults and puts the decoder in its wait-for-low state with no history.
`default_nettype none

module ir_pulse_width_frame_decoder #(
  parameter int TIMER_BITS = 13  // duration and since-frame counter width, 12..16
) (
  input wire logic    clk,
  input wire logic    rst_n,
  irpw_in_if.sink     in_ch,
  irpw_out_if.source  out_ch,
  irpw_cfg_if.sink    cfg_ch
);

  irpw_pkg::cfg_t    cfg;
  irpw_pkg::result_t core_res;
  irpw_pkg::result_t res_r;
  logic              core_emit;

  logic in_valid_r;
  logic in_pin_r;
  logic out_valid_r;
  logic advance;

  // sample moves into the step logic when the result register has room
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  irpw_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  irpw_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .pin    (in_pin_r),
    .cfg    (cfg),
    .emit   (core_emit),
    .result (core_res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_pin_r <= in_ch.pin_level;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && core_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_emit) begin
      res_r <= core_res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.frame_word    = res_r.frame_word;
  assign out_ch.player_field  = res_r.player_field;
  assign out_ch.data_field    = res_r.data_field;
  assign out_ch.check_field   = res_r.check_field;
  assign out_ch.check_ok      = res_r.check_ok;
  assign out_ch.frame_corrupt = res_r.frame_corrupt;
  assign out_ch.repeat_count  = res_r.repeat_count;

endmodule

`default_nettype wire

@@ dv/ir_pulse_width_frame_decoder_test.sv @@
// Self-checking testbench for the IR pulse-width frame decoder.
// Drives pin samples, config writes and result backpressure, predicts every result.
// Depends on irpw_pkg, the three channel interfaces and ir_pulse_width_frame_decoder.
`default_nettype none

module ir_pulse_width_frame_decoder_test;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int          DRAIN_CYCLES = 8;     // pipeline depth plus margin
  localparam int          HOLD_CYCLES  = 400;   // one long result-side stall
  // counters saturate here (TIMER_BITS = 13)
  localparam logic [irpw_pkg::CFG_W-1:0] TIMER_MAX = '1;

  localparam logic [1:0] PH_WAIT_LOW = 2'd0;
  localparam logic [1:0] PH_IN_HIGH  = 2'd1;
  localparam logic [1:0] PH_IN_LOW   = 2'd2;

  typedef enum {BRK_NONE, BRK_LOW, BRK_HIGH} pulse_fault_t;

  // -------------------------------------------------------------------------
  // Frame tracker: own copy of decoder state and registers. Every accepted
  // pin sample advances it; any frame it closes goes on pending_frames.
  // -------------------------------------------------------------------------
  class frame_tracker;
    irpw_pkg::cfg_t                  cfg;
    irpw_pkg::result_t               pending_frames[$];
    logic [1:0]                      ph;
    logic [irpw_pkg::POS_W-1:0]      pos;
    logic [irpw_pkg::FRAME_BITS-1:0] word;
    logic [irpw_pkg::CFG_W-1:0]      dur;
    logic [irpw_pkg::CFG_W-1:0]      since_last;
    bit                              rep_seen;
    logic [irpw_pkg::COUNT_W-1:0]    frames;
    int produced;
    int errors;

    function new();
      cfg.zero_low_min  = irpw_pkg::RST_ZERO_LOW_MIN;
      cfg.zero_low_max  = irpw_pkg::RST_ZERO_LOW_MAX;
      cfg.one_low_min   = irpw_pkg::RST_ONE_LOW_MIN;
      cfg.one_low_max   = irpw_pkg::RST_ONE_LOW_MAX;
      cfg.high_timeout  = irpw_pkg::RST_HIGH_TIMEOUT;
      cfg.repeat_window = irpw_pkg::RST_REPEAT_WINDOW;
      frames = '0;
      since_last = '0;
      produced = 0;
      errors = 0;
      start_over();
    endfunction

    function void start_over();
      ph = PH_WAIT_LOW;
      pos = '0;
      word = '0;
      dur = '0;
      rep_seen = 1'b0;
    endfunction

    function logic [irpw_pkg::CFG_W-1:0] bump(logic [irpw_pkg::CFG_W-1:0] v);
      return (v == TIMER_MAX) ? v : v + 1'b1;
    endfunction

    function void set_reg(logic [irpw_pkg::CFG_IDX_W-1:0] idx,
                          logic [irpw_pkg::CFG_W-1:0] val);
      case (idx)
        irpw_pkg::REG_ZERO_LOW_MIN:  cfg.zero_low_min  = val;
        irpw_pkg::REG_ZERO_LOW_MAX:  cfg.zero_low_max  = val;
        irpw_pkg::REG_ONE_LOW_MIN:   cfg.one_low_min   = val;
        irpw_pkg::REG_ONE_LOW_MAX:   cfg.one_low_max   = val;
        irpw_pkg::REG_HIGH_TIMEOUT:  cfg.high_timeout  = val;
        irpw_pkg::REG_REPEAT_WINDOW: cfg.repeat_window = val;
        default: ;
      endcase
    endfunction

    // Close the current frame, good or aborted.
    function void emit(bit corrupt);
      irpw_pkg::result_t r;
      r = '0;
      r.frame_word = word;
      r.frame_corrupt = corrupt;
      if (!corrupt) begin
        r.player_field = word[14:10];
        r.data_field   = word[9:5];
        r.check_field  = word[4:0];
        r.check_ok     = (word[4:0] == (word[14:10] ^ word[9:5]));
        frames = rep_seen ? frames + 1'b1 : irpw_pkg::COUNT_W'(1);
        since_last = '0;
        r.repeat_count = frames;
      end
      pending_frames.push_back(r);
      produced++;
      start_over();
    endfunction

    function void take_sample(bit pin);
      logic [irpw_pkg::CFG_W-1:0] prev_since;
      bit is_zero;
      bit is_one;
      prev_since = since_last;
      since_last = bump(since_last);
      is_zero = (dur > cfg.zero_low_min) && (dur < cfg.zero_low_max);
      is_one  = (dur > cfg.one_low_min) && (dur < cfg.one_low_max);
      case (ph)
        PH_IN_HIGH: begin
          if (pin) begin
            dur = bump(dur);
            if (dur >= cfg.high_timeout) emit(1'b1);
          end else begin
            ph = PH_IN_LOW;
            dur = irpw_pkg::CFG_W'(1);
          end
        end
        PH_IN_LOW: begin
          if (!pin) begin
            dur = bump(dur);
          end else if (!is_zero && !is_one) begin
            emit(1'b1);
          end else begin
            // zero test wins where the two ranges overlap
            if (frames == irpw_pkg::COUNT_W'(1) && prev_since <= cfg.repeat_window)
              rep_seen = 1'b1;
            word = {word[irpw_pkg::FRAME_BITS-2:0], !is_zero};
            pos = pos + 1'b1;
            if (pos >= irpw_pkg::FRAME_BITS) begin
              emit(1'b0);
            end else begin
              ph = PH_IN_HIGH;
              dur = '0;
            end
          end
        end
        default: begin
          if (!pin) begin
            ph = PH_IN_LOW;
            dur = irpw_pkg::CFG_W'(1);
          end
        end
      endcase
    endfunction

    function void compare_field(string field, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_frame(irpw_pkg::result_t got);
      irpw_pkg::result_t want;
      if (pending_frames.size() == 0) begin
        $display("%0t: unexpected result, expected none, got word %h", $time, got.frame_word);
        errors++;
        return;
      end
      want = pending_frames.pop_front();
      compare_field("frame_word",    want.frame_word,    got.frame_word);
      compare_field("player_field",  want.player_field,  got.player_field);
      compare_field("data_field",    want.data_field,    got.data_field);
      compare_field("check_field",   want.check_field,   got.check_field);
      compare_field("check_ok",      want.check_ok,      got.check_ok);
      compare_field("frame_corrupt", want.frame_corrupt, got.frame_corrupt);
      compare_field("repeat_count",  want.repeat_count,  got.repeat_count);
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, reset, channels, DUT
  // -------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #1 clk = ~clk;

  irpw_in_if  in_ch();
  irpw_out_if out_ch();
  irpw_cfg_if cfg_ch();

  ir_pulse_width_frame_decoder u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  frame_tracker   tracker;
  irpw_pkg::cfg_t cur;         // register values as the stimulus sees them
  int   in_gap_max  = 0;       // per-transaction idle bound, sender side
  int   out_gap_max = 6;       // per-transaction stall bound, receiver side
  int   len_cap     = 1 << 20; // keeps pulses short under wide-open bounds
  int   samples_sent = 0;
  bit   hold_armed   = 1'b0;   // asks the receiver for one long stall
  int unsigned cycle_count = 0;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ir_pulse_width_frame_decoder_test NOT OK");
      $finish;
    end
  end

  // Result monitor: check every result transaction against the oldest
  // pending expectation. Sampled at the rising edge, before DUT NBAs land.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.check_frame(irpw_pkg::result_t'({out_ch.frame_word, out_ch.player_field,
                                               out_ch.data_field, out_ch.check_field,
                                               out_ch.check_ok, out_ch.frame_corrupt,
                                               out_ch.repeat_count}));
  end

  // Result sink: per transaction draw a stall, applied once a result shows
  // up so the stall really lands on it. One long hold when armed.
  initial begin : result_sink
    int wait_cycles;
    out_ch.ready = 1'b0;
    while (!rst_n) @(negedge clk);
    forever begin
      wait_cycles = $urandom_range(0, out_gap_max);
      if (hold_armed) begin
        wait_cycles = HOLD_CYCLES;
        hold_armed = 1'b0;
      end
      if (wait_cycles > 0) begin
        out_ch.ready <= 1'b0;
        do @(posedge clk); while (!out_ch.valid);
        repeat (wait_cycles) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers. All called and returning at a falling edge.
  // -------------------------------------------------------------------------

  // One pin-sample transaction. valid stays high on return so back-to-back
  // samples never drop it; drain() lowers it.
  task automatic send_sample(bit lvl);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.pin_level <= lvl;
    do @(posedge clk); while (!in_ch.ready);
    tracker.take_sample(lvl);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic send_run(bit lvl, int n);
    repeat (n) send_sample(lvl);
  endtask

  task automatic send_idle(int n);
    send_run(1'b1, n);
  endtask

  // Low length strictly inside (lo, hi), biased toward both edges.
  function automatic int pick_len(int lo, int hi);
    int top;
    int r;
    top = (hi - lo > len_cap) ? lo + len_cap : hi;
    r = $urandom_range(0, 3);
    if (r == 0) return lo + 1;
    if (r == 1) return top - 1;
    return $urandom_range(lo + 1, top - 1);
  endfunction

  function automatic logic [irpw_pkg::FRAME_BITS-1:0] rand_word();
    logic [irpw_pkg::FRAME_BITS-1:0] w;
    w = irpw_pkg::FRAME_BITS'($urandom);
    if ($urandom_range(0, 1)) w[4:0] = w[14:10] ^ w[9:5];
    return w;
  endfunction

  // Sixteen pulses MSB first. A fault at bit fault_at stops sending there: a low
  // on a range bound or above one_low_max, or a high of timeout + 1 samples (edge
  // sample plus timeout counted samples). Last bit ends on its single edge sample.
  task automatic send_frame(logic [irpw_pkg::FRAME_BITS-1:0] word, pulse_fault_t fault,
                            int fault_at, int hi_cap);
    int low_len;
    int hmax;
    hmax = (hi_cap < cur.high_timeout) ? hi_cap : cur.high_timeout;
    for (int i = irpw_pkg::FRAME_BITS - 1; i >= 0; i--) begin
      if (word[i]) low_len = pick_len(cur.one_low_min, cur.one_low_max);
      else         low_len = pick_len(cur.zero_low_min, cur.zero_low_max);
      if (fault == BRK_LOW && i == fault_at) begin
        case ($urandom_range(0, 4))
          0: low_len = cur.zero_low_min;
          1: low_len = cur.zero_low_max;
          2: low_len = cur.one_low_min;
          3: low_len = cur.one_low_max;
          default: low_len = cur.one_low_max + $urandom_range(1, 4);
        endcase
        if (low_len < 1) low_len = 1;
      end
      send_run(1'b0, low_len);
      if (fault != BRK_NONE && i == fault_at) begin
        send_run(1'b1, (fault == BRK_HIGH) ? cur.high_timeout + 1 : 1);
        return;
      end
      send_run(1'b1, (i == 0) ? 1 : $urandom_range(1, hmax));
    end
  endtask

  // Wait out every pending result, then the pipeline of no-result samples.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (tracker.pending_frames.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // valid stays high across back-to-back writes; apply_cfg lowers it.
  task automatic write_reg(logic [irpw_pkg::CFG_IDX_W-1:0] idx,
                           logic [irpw_pkg::CFG_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    tracker.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic apply_cfg(int zmin, int zmax, int omin, int omax, int tmo, int rwin);
    drain();
    cur.zero_low_min  = irpw_pkg::CFG_W'(zmin);
    cur.zero_low_max  = irpw_pkg::CFG_W'(zmax);
    cur.one_low_min   = irpw_pkg::CFG_W'(omin);
    cur.one_low_max   = irpw_pkg::CFG_W'(omax);
    cur.high_timeout  = irpw_pkg::CFG_W'(tmo);
    cur.repeat_window = irpw_pkg::CFG_W'(rwin);
    write_reg(irpw_pkg::REG_ZERO_LOW_MIN,  cur.zero_low_min);
    write_reg(irpw_pkg::REG_ZERO_LOW_MAX,  cur.zero_low_max);
    write_reg(irpw_pkg::REG_ONE_LOW_MIN,   cur.one_low_min);
    write_reg(irpw_pkg::REG_ONE_LOW_MAX,   cur.one_low_max);
    write_reg(irpw_pkg::REG_HIGH_TIMEOUT,  cur.high_timeout);
    write_reg(irpw_pkg::REG_REPEAT_WINDOW, cur.repeat_window);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly well-formed frames with random content and spacing around the
  // repeat window; the rest broken frames and pin noise.
  task automatic run_random(int n_items, int n_frames);
    int s0;
    int f0;
    int pick;
    s0 = samples_sent;
    f0 = tracker.produced;
    while ((samples_sent - s0) < n_items || (tracker.produced - f0) < n_frames) begin
      if ($urandom_range(0, 7) == 0) begin
        in_gap_max  = $urandom_range(0, 1) * 6;
        out_gap_max = $urandom_range(0, 1) * 6;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame(rand_word(), BRK_NONE, 0, 6);
        send_idle($urandom_range(0, cur.repeat_window + 10));
      end else if (pick < 85) begin
        send_frame(rand_word(), (pick < 78) ? BRK_LOW : BRK_HIGH, $urandom_range(0, 15), 6);
      end else begin
        repeat ($urandom_range(1, 8)) send_run(1'($urandom_range(0, 1)), $urandom_range(1, 12));
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  initial begin : stimulus
    int zmin;
    int zmax;
    int omin;
    tracker = new();
    cur = tracker.cfg;
    in_ch.valid     = 1'b0;
    in_ch.pin_level = 1'b1;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = irpw_pkg::REG_ZERO_LOW_MIN;
    cfg_ch.data     = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset register values: idle high before bit 0 just waits, and a
    // 3-tick low fits neither bit range, so the frame aborts empty.
    in_gap_max = 0;
    send_idle(20);
    send_run(1'b0, 3);
    send_run(1'b1, 1);
    send_idle(4);

    // Short pulses: zero = 2..3 ticks, one = 5..6, timeout 8.
    apply_cfg(1, 4, 4, 7, 8, 300);
    in_gap_max = 6;
    send_frame(16'hFFFF, BRK_NONE, 0, 2);
    send_idle(10);
    send_frame(16'h0000, BRK_NONE, 0, 2);    // repeat
    send_idle(5);
    send_frame(rand_word(), BRK_NONE, 0, 2); // after a repeat: fresh again
    send_run(1'b0, 1);                       // low equal to the exclusive min
    send_run(1'b1, 1);
    send_frame(rand_word(), BRK_LOW, 13, 2);
    send_frame(rand_word(), BRK_HIGH, 13, 2);

    // Backpressure: a corrupt result every two samples while the receiver
    // holds off, so the result and input stages fill and input stalls.
    hold_armed = 1'b1;
    in_gap_max = 0;
    repeat (50) begin
      send_run(1'b0, 1);
      send_run(1'b1, 1);
    end

    // Wide-open overlapping ranges (zero test wins), timeout 1, window 0.
    apply_cfg(0, 8191, 0, 8191, 1, 0);
    len_cap = 6;
    send_frame(rand_word(), BRK_NONE, 0, 1);
    send_frame(rand_word(), BRK_NONE, 0, 1);  // window 0: never a repeat
    send_run(1'b0, 40);                       // long low, still a zero bit
    send_run(1'b1, 1);
    send_run(1'b1, 2);                        // first counted high times out

    // No zero range, all-ones range, top timeout and window.
    apply_cfg(8191, 0, 0, 8191, 8191, 8191);
    send_idle(20);
    send_frame(16'hFFFF, BRK_NONE, 0, 3);
    send_frame(16'hFFFF, BRK_NONE, 0, 3);     // repeat under the widest window
    len_cap = 1 << 20;

    // Random register settings, random traffic.
    repeat (2) begin
      zmin = $urandom_range(0, 3);
      zmax = zmin + $urandom_range(2, 6);
      omin = $urandom_range(zmin, zmax + 3);
      apply_cfg(zmin, zmax, omin, omin + $urandom_range(2, 6),
                $urandom_range(1, 10), $urandom_range(0, 60));
      run_random(70, 1);
    end

    drain();
    if (tracker.errors == 0) begin
      $display("ir_pulse_width_frame_decoder_test OK");
    end else begin
      $display("ir_pulse_width_frame_decoder_test NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
